[hdl/hsl_pkg.sv]
// Shared types and constants for the RGB to HSL converter.
// Depends on nothing; every other file in the block imports it.
`default_nettype none

package hsl_pkg;

	localparam int CompW   = 8;
	localparam int FracW   = 16;
	// remainder and divisor width: the largest divisor is six times 255
	localparam int RemW    = 11;
	localparam int NumCells = FracW;
	localparam int NumLanes = 3;
	localparam int Latency  = NumCells + 1;

	localparam int LaneHue   = 0;
	localparam int LaneSat   = 1;
	localparam int LaneLight = 2;

	localparam logic [RemW-1:0] LightDen = RemW'(510);

	typedef struct packed {
		logic [CompW-1:0] red;
		logic [CompW-1:0] green;
		logic [CompW-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FracW-1:0] hue;
		logic [FracW-1:0] saturation;
		logic [FracW-1:0] lightness;
	} hsl_t;

	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [RemW-1:0]  den;
		logic [FracW-1:0] quo;
		logic             full;
	} lane_t;

	typedef struct packed {
		logic                      valid;
		lane_t [NumLanes-1:0]      lane;
	} stage_t;

endpackage

`default_nettype wire

[hdl/hsl_front.sv]
// Front stage: sorts the components, picks the sextant and loads the three divider lanes.
// Depends on hsl_pkg.
`default_nettype none

module hsl_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire hsl_pkg::pixel_t pixel,
	output hsl_pkg::stage_t      stage
);
	import hsl_pkg::*;

	typedef enum logic [1:0] {
		ChanRed,
		ChanGreen,
		ChanBlue
	} chan_t;

	logic [CompW-1:0] hi, lo, diff;
	chan_t            chan;
	logic [CompW:0]   sum, den_s;
	logic [RemW-1:0]  den6;
	logic signed [RemW:0] sr, sg, sb, sd, num_h, num_w;
	stage_t           nxt;
	logic             valid_s1;
	lane_t [NumLanes-1:0] lane_s1;

	always_comb begin
		if (pixel.red < pixel.green) begin
			if (pixel.blue < pixel.red) begin
				lo = pixel.blue; hi = pixel.green; chan = ChanGreen;
			end else begin
				lo = pixel.red;
				if (pixel.green < pixel.blue) begin
					hi = pixel.blue; chan = ChanBlue;
				end else begin
					hi = pixel.green; chan = ChanGreen;
				end
			end
		end else begin
			if (pixel.green > pixel.blue) begin
				lo = pixel.blue; hi = pixel.red; chan = ChanRed;
			end else begin
				lo = pixel.green;
				if (pixel.red < pixel.blue) begin
					hi = pixel.blue; chan = ChanBlue;
				end else begin
					hi = pixel.red; chan = ChanRed;
				end
			end
		end
	end

	always_comb begin
		sum   = {1'b0, hi} + {1'b0, lo};
		diff  = hi - lo;
		den_s = (sum < (CompW+1)'(255)) ? sum : ((CompW+1)'(510) - sum);
		den6  = {1'b0, diff, 2'b00} + {2'b00, diff, 1'b0};

		sr = $signed({4'b0000, pixel.red});
		sg = $signed({4'b0000, pixel.green});
		sb = $signed({4'b0000, pixel.blue});
		sd = $signed({4'b0000, diff});
		case (chan)
			ChanRed:   num_h = sg - sb;
			ChanGreen: num_h = (sd <<< 1) + sb - sr;
			ChanBlue:  num_h = (sd <<< 2) + sr - sg;
			default:   num_h = '0;
		endcase
		// wrap negative sextant positions into the last turn
		num_w = (num_h < 0) ? (num_h + $signed({1'b0, den6})) : num_h;

		nxt.valid = take;
		// grey pixel: divide zero by one so hue and saturation come out zero
		if (diff == '0) begin
			nxt.lane[LaneHue].rem = '0;
			nxt.lane[LaneHue].den = RemW'(1);
			nxt.lane[LaneSat].rem = '0;
			nxt.lane[LaneSat].den = RemW'(1);
		end else begin
			nxt.lane[LaneHue].rem = num_w[RemW-1:0];
			nxt.lane[LaneHue].den = den6;
			nxt.lane[LaneSat].rem = RemW'(diff);
			nxt.lane[LaneSat].den = RemW'(den_s);
		end
		nxt.lane[LaneHue].full   = 1'b0;
		nxt.lane[LaneSat].full   = (diff != '0) && ({1'b0, diff} == den_s);
		nxt.lane[LaneLight].rem  = RemW'(sum);
		nxt.lane[LaneLight].den  = LightDen;
		nxt.lane[LaneLight].full = (RemW'(sum) == LightDen);
		for (int i = 0; i < NumLanes; i++) begin
			nxt.lane[i].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= nxt.lane;
	end

	assign stage.valid = valid_s1;
	assign stage.lane  = lane_s1;

endmodule

`default_nettype wire

[hdl/hsl_div_cell.sv]
// One cell of the divider chain: works out one quotient bit for each of the three lanes.
// Depends on hsl_pkg.
`default_nettype none

module hsl_div_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hsl_pkg::stage_t prev,
	output hsl_pkg::stage_t      next
);
	import hsl_pkg::*;

	lane_t [NumLanes-1:0] lane_d, lane_q;
	logic                 valid_q;
	logic [RemW:0]        dbl [NumLanes];
	logic [RemW:0]        dif [NumLanes];
	logic                 ge  [NumLanes];

	always_comb begin
		for (int i = 0; i < NumLanes; i++) begin
			dbl[i] = {prev.lane[i].rem, 1'b0};
			ge[i]  = (dbl[i] >= {1'b0, prev.lane[i].den});
			dif[i] = dbl[i] - {1'b0, prev.lane[i].den};
			lane_d[i].rem  = ge[i] ? dif[i][RemW-1:0] : dbl[i][RemW-1:0];
			lane_d[i].den  = prev.lane[i].den;
			lane_d[i].quo  = {prev.lane[i].quo[FracW-2:0], ge[i]};
			lane_d[i].full = prev.lane[i].full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		lane_q <= lane_d;
	end

	assign next.valid = valid_q;
	assign next.lane  = lane_q;

endmodule

`default_nettype wire

[hdl/rgb_to_hsl_converter.sv]
// RGB to HSL converter: one pixel in, one hue/saturation/lightness result out.
// A new pixel is taken in every cycle; busy stays low, since the chain never stalls.
// The pipeline is one front stage plus sixteen divider cells, one quotient bit per cell.
// Reset clears the valid bits of every stage; data in flight is dropped.
// Depends on hsl_pkg, hsl_front and hsl_div_cell.
`default_nettype none

module rgb_to_hsl_converter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire hsl_pkg::pixel_t pixel,
	output logic                 done,
	output hsl_pkg::hsl_t        result
);
	import hsl_pkg::*;

	stage_t chain [NumCells+1];

	assign busy = 1'b0;

	hsl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start && !busy),
		.pixel  (pixel),
		.stage  (chain[0])
	);

	for (genvar c = 0; c < NumCells; c++) begin : g_cell
		hsl_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (chain[c]),
			.next   (chain[c+1])
		);
	end

	// a ratio of exactly one saturates to the largest fraction
	assign done              = chain[NumCells].valid;
	assign result.hue        = chain[NumCells].lane[LaneHue].quo
	                           | {FracW{chain[NumCells].lane[LaneHue].full}};
	assign result.saturation = chain[NumCells].lane[LaneSat].quo
	                           | {FracW{chain[NumCells].lane[LaneSat].full}};
	assign result.lightness  = chain[NumCells].lane[LaneLight].quo
	                           | {FracW{chain[NumCells].lane[LaneLight].full}};

endmodule

`default_nettype wire

[hdl/hsl_checker.sv]
// Port-level checks for the RGB to HSL converter, bound to the top level.
// Depends on hsl_pkg.
`default_nettype none

module hsl_port_checks (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire logic            done,
	input wire hsl_pkg::hsl_t   result
);
	import hsl_pkg::*;

	// the chain never holds off a transfer
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every result traces back to a pixel that passed through the front stage and every divider cell
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Latency))
		else $error("result without a pixel behind it");

	// black carries neither hue nor saturation
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.lightness == '0) |-> (result.hue == '0 && result.saturation == '0))
		else $error("black pixel with hue or saturation");

	// zero saturation only happens for grey, whose hue is zero
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturation == '0) |-> (result.hue == '0))
		else $error("grey pixel with nonzero hue");

	// full lightness is only reached by white, which is grey
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.lightness == '1) |-> (result.saturation == '0))
		else $error("white pixel with saturation");

endmodule

bind rgb_to_hsl_converter hsl_port_checks u_hsl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

[tb/hsl_checker.sv]
// Checker for the RGB to HSL converter: watches pixel and result transfers,
// predicts each result and compares it field by field. Depends on hsl_pkg.
`timescale 1ns / 100ps

module hsl_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            busy,
	input  wire hsl_pkg::pixel_t pixel,
	input  wire logic            done,
	input  wire hsl_pkg::hsl_t   result,
	output int                   errors,
	output int                   outstanding
);
	import hsl_pkg::*;

	typedef enum logic [1:0] {ChanRed, ChanGreen, ChanBlue} chan_t;

	hsl_t expected_hsl[$];

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	// Truncated Q0.16 ratio; exactly 1.0 saturates to all ones.
	function automatic logic [FracW-1:0] q16_ratio(input int num, input int den);
		longint q;
		if (den == 0) return '0;
		q = (longint'(num) * 65536) / den;
		return (q > 65535) ? {FracW{1'b1}} : q[FracW-1:0];
	endfunction

	function automatic hsl_t predict_hsl(input pixel_t px);
		int    r, g, b, hi, lo, spread, total, num;
		chan_t chan;
		hsl_t  res;
		r = px.red;
		g = px.green;
		b = px.blue;
		// ties resolve in a fixed order; the hue comes out the same either way
		if (r < g) begin
			if (b < r) begin
				lo = b; hi = g; chan = ChanGreen;
			end else begin
				lo = r;
				if (g < b) begin
					hi = b; chan = ChanBlue;
				end else begin
					hi = g; chan = ChanGreen;
				end
			end
		end else begin
			if (g > b) begin
				lo = b; hi = r; chan = ChanRed;
			end else begin
				lo = g;
				if (r < b) begin
					hi = b; chan = ChanBlue;
				end else begin
					hi = r; chan = ChanRed;
				end
			end
		end
		total = hi + lo;
		spread = hi - lo;
		res = '0;
		res.lightness = q16_ratio(total, 510);
		// grey pixels keep hue and saturation at zero
		if (spread > 0) begin
			res.saturation = q16_ratio(spread, (total < 255) ? total : 510 - total);
			case (chan)
				ChanRed:   num = g - b;
				ChanGreen: num = 2 * spread + (b - r);
				default:   num = 4 * spread + (r - g);
			endcase
			// wrap into one full turn
			if (num < 0) num += 6 * spread;
			res.hue = q16_ratio(num, 6 * spread);
		end
		return res;
	endfunction

	task automatic report_field(input string field, input logic [FracW-1:0] exp_val,
			input logic [FracW-1:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		hsl_t exp_res;
		if (arst_n) begin
			if (start && !busy) expected_hsl.push_back(predict_hsl(pixel));
			if (done === 1'b1) begin
				if (expected_hsl.size() == 0) begin
					$display("%0t: result with nothing expected, got %h", $time, result);
					errors++;
				end else begin
					exp_res = expected_hsl.pop_front();
					report_field("hue", exp_res.hue, result.hue);
					report_field("saturation", exp_res.saturation, result.saturation);
					report_field("lightness", exp_res.lightness, result.lightness);
				end
			end
			outstanding = expected_hsl.size();
		end
	end

endmodule

[tb/tb_rgb_to_hsl_converter.sv]
// Top of the RGB to HSL converter testbench: clock, reset, pixel stimulus and verdict.
// Depends on hsl_pkg, rgb_to_hsl_converter and hsl_checker.
`timescale 1ns / 100ps

module tb_rgb_to_hsl_converter;
	import hsl_pkg::*;

	localparam int NumRandom = 1500;
	localparam int StallLimit = 2000;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	pixel_t pixel;
	logic   done;
	hsl_t   result;
	int     errors;
	int     outstanding;
	int     quiet_cycles;

	rgb_to_hsl_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	hsl_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pixel       (pixel),
		.done        (done),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort when neither a pixel nor a result has moved for too long.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done === 1'b1) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= StallLimit) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_pixel(input pixel_t px, input bit may_idle);
		@(negedge clk);
		while (may_idle && $urandom_range(99) < 35) begin
			start <= 1'b0;
			pixel <= pixel_t'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Hold the sender until every result in flight has come back.
	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	function automatic logic [CompW-1:0] near(input int base, input int offs);
		int v;
		v = base + offs;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[CompW-1:0];
	endfunction

	function automatic logic [CompW-1:0] edge_value;
		case ($urandom_range(2))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pixel_t random_pixel;
		pixel_t px;
		int     base;
		int     pick;
		px = pixel_t'($urandom);
		pick = $urandom_range(9);
		if (pick == 6 || pick == 7) begin
			// close to grey: tiny spreads stress the dividers
			base = $urandom_range(255);
			px.red   = near(base, $urandom_range(4) - 2);
			px.green = near(base, $urandom_range(4) - 2);
			px.blue  = near(base, $urandom_range(4) - 2);
		end else if (pick == 8) begin
			px = {edge_value(), edge_value(), edge_value()};
		end else if (pick == 9) begin
			case ($urandom_range(2))
				0:       px.green = px.red;
				1:       px.blue = px.green;
				default: px.red = px.blue;
			endcase
		end
		return px;
	endfunction

	pixel_t directed_px [22] = '{
		'{8'd0,   8'd0,   8'd0},
		'{8'd255, 8'd255, 8'd255},
		'{8'd255, 8'd0,   8'd0},
		'{8'd0,   8'd255, 8'd0},
		'{8'd0,   8'd0,   8'd255},
		'{8'd255, 8'd255, 8'd0},
		'{8'd0,   8'd255, 8'd255},
		'{8'd255, 8'd0,   8'd255},
		'{8'd128, 8'd128, 8'd128},
		'{8'd1,   8'd1,   8'd1},
		'{8'd1,   8'd0,   8'd0},
		'{8'd0,   8'd0,   8'd1},
		'{8'd255, 8'd0,   8'd1},
		'{8'd254, 8'd0,   8'd0},
		'{8'd200, 8'd56,  8'd56},
		'{8'd100, 8'd200, 8'd200},
		'{8'd200, 8'd100, 8'd200},
		'{8'd128, 8'd127, 8'd127},
		'{8'd255, 8'd254, 8'd254},
		'{8'd170, 8'd85,  8'd0},
		'{8'd85,  8'd170, 8'd255},
		'{8'd254, 8'd255, 8'd253}
	};

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		pixel  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_px[i]) send_pixel(directed_px[i], 1'b1);
		drain();

		for (int i = 0; i < NumRandom; i++) begin
			if (i == 1000) drain();
			// a long back-to-back burst in the middle
			send_pixel(random_pixel(), !(i inside {[600:899]}));
		end

		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);

		if (errors == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/hsl_pkg.sv
hdl/hsl_front.sv
hdl/hsl_div_cell.sv
hdl/rgb_to_hsl_converter.sv
hdl/hsl_checker.sv
tb/hsl_checker.sv
tb/tb_rgb_to_hsl_converter.sv
